// File: design/slot_table_id_allocator_assert.svh
// Assertion macros for the slot table checker
`ifndef SLOT_TABLE_ID_ALLOCATOR_ASSERT_SVH
`define SLOT_TABLE_ID_ALLOCATOR_ASSERT_SVH
`define STA_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define STA_ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

// File: design/sta_pkg.sv
// ----------------------------------------------------------------------------
// sta_pkg
// Types and codes shared by the slot table allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package sta_pkg;
   localparam int SLOTS      = 256;
   localparam int VALUE_BITS = 32;

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_ASSIGN  = 3'd1,
      OP_ERASE   = 3'd2,
      OP_FETCH   = 3'd3,
      OP_STEP_FW = 3'd4,
      OP_STEP_RV = 3'd5
   } op_type;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_TABLE_FULL = 2'd1;
   localparam logic [1:0] ST_QUEUE_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  slot_id;
      logic [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  result_id;
      logic [31:0] result_value;
      logic [8:0]  live_count;
      logic        at_end;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_EXEC,
      BK_SCAN,
      BK_CLEAR
   } bk_state_type;
endpackage
`default_nettype wire

// File: design/sta_front.sv
// ----------------------------------------------------------------------------
// sta_front
// Input stage and two-entry queue that decouples accept from execution.
// ----------------------------------------------------------------------------
`default_nettype none
module sta_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire sta_pkg::req_type req_data,
   output logic                 q_valid,
   output sta_pkg::req_type     q_data,
   input  wire logic            q_take
);
   sta_pkg::req_type mem_ff [2];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = mem_ff[rd_ff];

   always_comb begin
      rd_in  = rd_ff ^ q_take;
      wr_in  = wr_ff ^ push;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= req_data;
   end
endmodule
`default_nettype wire

// File: design/sta_back.sv
// ----------------------------------------------------------------------------
// sta_back
// Executes table operations: value memory, free FIFO, high-water mark.
// ----------------------------------------------------------------------------
`default_nettype none
module sta_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire sta_pkg::req_type q_data,
   output logic                  q_take,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sta_pkg::rsp_type      rsp_data
);
   localparam int SLOTS      = sta_pkg::SLOTS;
   localparam int VALUE_BITS = sta_pkg::VALUE_BITS;
   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
   localparam logic [AW-1:0] LAST_C  = AW'(SLOTS - 1);

   logic [VALUE_BITS-1:0] vmem [SLOTS];
   logic [AW-1:0]         fmem [SLOTS];

   sta_pkg::bk_state_type st_ff, st_in;
   sta_pkg::req_type      cur_ff;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] fcnt_ff, fcnt_in, hw_ff, hw_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [VALUE_BITS-1:0] rdv_ff;
   logic [AW-1:0]         rdf_ff;
   logic [AW-1:0] raddr;
   logic          we;
   logic [AW-1:0] waddr;
   logic [VALUE_BITS-1:0] wdata;
   logic          fwe;
   sta_pkg::rsp_type out_ff, out_in;
   logic ov_ff, ov_in;
   logic [31:0]   val32;
   logic [VALUE_BITS-1:0] ival;
   logic          fwd;
   logic [CW-1:0] rv_start;

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;
   assign ival   = VALUE_BITS'(cur_ff.item_value);
   assign fwd    = (cur_ff.operation == sta_pkg::OP_STEP_FW);
   assign rv_start = (CW'(cur_ff.slot_id) >= hw_ff) ? hw_ff : CW'(cur_ff.slot_id);
   assign val32  = 32'(rdv_ff);

   function automatic logic [8:0] live(input logic [CW-1:0] h, input logic [CW-1:0] f);
      live = (h > f) ? 9'(h - f) : 9'd0;
   endfunction

   // state register and memories
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= sta_pkg::BK_CLEAR;
         head_ff <= '0;
         tail_ff <= '0;
         fcnt_ff <= '0;
         hw_ff   <= '0;
         ov_ff   <= 1'b0;
         clr_ff  <= '0;
      end else begin
         st_ff   <= st_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         fcnt_ff <= fcnt_in;
         hw_ff   <= hw_in;
         ov_ff   <= ov_in;
         clr_ff  <= clr_in;
      end
      idx_ff <= idx_in;
      out_ff <= out_in;
      if (q_take) cur_ff <= q_data;
      rdv_ff <= vmem[raddr];
      rdf_ff <= fmem[head_ff];
      if (we) vmem[waddr] <= wdata;
      if (fwe) fmem[tail_ff] <= AW'(cur_ff.slot_id);
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         sta_pkg::BK_CLEAR: if (clr_ff == LAST_C) st_in = sta_pkg::BK_IDLE;
         sta_pkg::BK_IDLE:  if (q_valid && !(ov_ff && rsp_stall)) st_in = sta_pkg::BK_READ;
         sta_pkg::BK_READ:  st_in = sta_pkg::BK_EXEC;
         sta_pkg::BK_EXEC: begin
            if (cur_ff.operation == sta_pkg::OP_STEP_FW ||
                cur_ff.operation == sta_pkg::OP_STEP_RV) st_in = sta_pkg::BK_SCAN;
            else st_in = sta_pkg::BK_IDLE;
         end
         sta_pkg::BK_SCAN: begin
            if (fwd) begin
               if (idx_ff >= hw_ff || idx_ff == '0 ||
                   (rdv_ff != '0 && idx_ff != CW'(cur_ff.slot_id)))
                  st_in = sta_pkg::BK_IDLE;
            end else if (idx_ff == '0 || rdv_ff != '0) st_in = sta_pkg::BK_IDLE;
            // idle transition handled with output below
         end
         default: st_in = sta_pkg::BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_take  = (st_ff == sta_pkg::BK_IDLE) && q_valid && !(ov_ff && rsp_stall);
      ov_in   = ov_ff && rsp_stall;
      out_in  = out_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      fcnt_in = fcnt_ff;
      hw_in   = hw_ff;
      idx_in  = idx_ff;
      clr_in  = clr_ff;
      raddr   = AW'(cur_ff.slot_id);
      we      = 1'b0;
      waddr   = AW'(cur_ff.slot_id);
      wdata   = '0;
      fwe     = 1'b0;
      case (st_ff)
         sta_pkg::BK_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            clr_in = clr_ff + 1'b1;
         end
         sta_pkg::BK_IDLE: begin
            raddr = AW'(q_data.slot_id);
         end
         sta_pkg::BK_READ: begin
            raddr = AW'(cur_ff.slot_id);
         end
         sta_pkg::BK_EXEC: begin
            out_in.result_id    = '0;
            out_in.result_value = '0;
            out_in.at_end       = 1'b0;
            out_in.status       = sta_pkg::ST_OK;
            case (cur_ff.operation)
               sta_pkg::OP_INSERT: begin
                  if (fcnt_ff != '0) begin
                     we = 1'b1; waddr = rdf_ff; wdata = ival;
                     head_in = (head_ff == LAST_C) ? '0 : head_ff + 1'b1;
                     fcnt_in = fcnt_ff - 1'b1;
                     out_in.result_id = 8'(rdf_ff);
                     out_in.result_value = 32'(ival);
                  end else if (hw_ff < SLOTS_C) begin
                     we = 1'b1; waddr = AW'(hw_ff); wdata = ival;
                     hw_in = hw_ff + 1'b1;
                     out_in.result_id = 8'(hw_ff);
                     out_in.result_value = 32'(ival);
                  end else out_in.status = sta_pkg::ST_TABLE_FULL;
               end
               sta_pkg::OP_ASSIGN: begin
                  out_in.result_id = cur_ff.slot_id;
                  if (CW'(cur_ff.slot_id) < SLOTS_C) begin
                     we = 1'b1; wdata = ival;
                     if (CW'(cur_ff.slot_id) + 1'b1 > hw_ff)
                        hw_in = CW'(cur_ff.slot_id) + 1'b1;
                     out_in.result_value = 32'(ival);
                  end
               end
               sta_pkg::OP_ERASE: begin
                  out_in.result_id = cur_ff.slot_id;
                  if (CW'(cur_ff.slot_id) < SLOTS_C && CW'(cur_ff.slot_id) < hw_ff) begin
                     if (fcnt_ff >= SLOTS_C) begin
                        out_in.status = sta_pkg::ST_QUEUE_FULL;
                        out_in.result_value = val32;
                     end else begin
                        we = 1'b1; wdata = '0; fwe = 1'b1;
                        tail_in = (tail_ff == LAST_C) ? '0 : tail_ff + 1'b1;
                        fcnt_in = fcnt_ff + 1'b1;
                     end
                  end
               end
               sta_pkg::OP_FETCH: begin
                  out_in.result_id = cur_ff.slot_id;
                  if (CW'(cur_ff.slot_id) < SLOTS_C) out_in.result_value = val32;
               end
               default: ;
            endcase
            out_in.live_count = live(hw_in, fcnt_in);
            if (fwd) begin
               idx_in = CW'(cur_ff.slot_id) + 1'b1;
               raddr  = AW'(CW'(cur_ff.slot_id) + 1'b1);
            end else begin
               idx_in = rv_start;
               raddr  = AW'(rv_start - 1'b1);
            end
            if (cur_ff.operation != sta_pkg::OP_STEP_FW &&
                cur_ff.operation != sta_pkg::OP_STEP_RV) ov_in = 1'b1;
         end
         sta_pkg::BK_SCAN: begin
            // idx_ff: forward = slot now read; reverse = slot above one read
            if (fwd) begin
               if (idx_ff >= hw_ff || idx_ff == '0) begin
                  ov_in = 1'b1; out_in.at_end = 1'b1;
               end else if (rdv_ff != '0) begin
                  ov_in = 1'b1; out_in.result_id = 8'(idx_ff);
                  out_in.result_value = val32;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  raddr  = AW'(idx_ff + 1'b1);
               end
            end else begin
               if (idx_ff == '0) begin
                  ov_in = 1'b1; out_in.at_end = 1'b1;
               end else if (rdv_ff != '0) begin
                  ov_in = 1'b1; out_in.result_id = 8'(idx_ff - 1'b1);
                  out_in.result_value = val32;
               end else begin
                  idx_in = idx_ff - 1'b1;
                  raddr  = AW'(idx_ff - 2'd2);
               end
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// File: design/slot_table_id_allocator.sv
// ----------------------------------------------------------------------------
// slot_table_id_allocator
// Slot table handing out identities with a FIFO free list.
// ----------------------------------------------------------------------------
// An item passes through the executor states in order (take, memory read, then one
// read-modify-write of the value memory and free FIFO); a two-entry queue in
// front lets the sender run ahead. Steps examine one slot at a time, as
// set by the single value-memory read port.
// After reset a clearing pass writes all 256 slots before the first item.
`default_nettype none
module slot_table_id_allocator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sta_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sta_pkg::rsp_type      rsp_data
);
   logic             q_valid, q_take;
   sta_pkg::req_type q_data;

   sta_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_data, .q_take
   );

   sta_back u_back (
      .clock, .reset, .q_valid, .q_data, .q_take,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
`default_nettype wire

// File: design/sta_checker.sv
// ----------------------------------------------------------------------------
// sta_checker
// Port-level checks for the slot table allocator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "slot_table_id_allocator_assert.svh"
module sta_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire sta_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire sta_pkg::rsp_type rsp_data
);
   logic end_rsp, end_clean, full_rsp, code_ok;

   assign end_rsp   = rsp_valid && rsp_data.at_end;
   assign end_clean = (rsp_data.status == sta_pkg::ST_OK) && (rsp_data.result_id == 8'd0);
   assign full_rsp  = rsp_valid && (rsp_data.status == sta_pkg::ST_TABLE_FULL);
   assign code_ok   = (rsp_data.status <= sta_pkg::ST_QUEUE_FULL);

   `STA_ASSERT_NXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_data))
   `STA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `STA_ASSERT_IMP(a_status, clock, reset, rsp_valid, code_ok)
   `STA_ASSERT_IMP(a_end_ok, clock, reset, end_rsp, end_clean)
   `STA_ASSERT_IMP(a_full, clock, reset, full_rsp, rsp_data.result_value == 32'd0)
endmodule

bind slot_table_id_allocator sta_checker u_checker (
   .clock, .reset, .req_valid, .req_stall, .req_data,
   .rsp_valid, .rsp_stall, .rsp_data
);
`default_nettype wire
